/* hdl/degh_pkg.sv */
// Shared constants and helpers for the dual EGH pulse evaluator.
`default_nettype none

package degh_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int EXP_TERMS = 12;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_AMP_FIRST    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_AMP_SECOND   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TAIL_FIRST   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TAIL_SECOND  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CENTRE_TIME  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH_FIRST  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH_SECOND = 3'd6;

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [30:0] ONE_Q30   = 31'd1073741824;

    // floor(2^31 / k)
    localparam logic [31:0] RECIP_Q31 [1:12] = '{
        32'd2147483648, 32'd1073741824, 32'd715827882, 32'd536870912,
        32'd429496729,  32'd357913941,  32'd306783378, 32'd268435456,
        32'd238609294,  32'd214748364,  32'd195225786, 32'd178956970
    };

    // start-to-done latency in cycles
    function automatic int pipe_latency(input int frac);
        return frac + 51;
    endfunction

endpackage

`default_nettype wire

/* hdl/degh_peak.sv */
// One EGH peak: mask, pipelined divide, exp series and amplitude scaling.
`default_nettype none

module degh_peak #(
    parameter int FRAC_BITS = degh_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic signed [32:0] dt,
    input  logic        [31:0] adt,
    input  logic signed [31:0] amp,
    input  logic signed [31:0] tau,
    input  logic        [30:0] sigma,
    output logic signed [33:0] peak
);

    localparam int QB = FRAC_BITS + 5;
    localparam int MW = 66 - FRAC_BITS;
    localparam int DW = MW - 1;
    localparam int CW = DW + QB;
    localparam int YW = QB + 31;
    localparam int TERMS = degh_pkg::EXP_TERMS;

    typedef struct packed {
        logic [29:0] u;
        logic [5:0]  n;
        logic        zero;
    } carry_t;

    logic        [61:0] ss;
    logic        [62:0] sq_reg;
    logic signed [64:0] tb_reg;
    logic        [63:0] num1_reg;

    assign ss = sigma * sigma;

    always_ff @(posedge clk)
    begin
        sq_reg   <= {ss, 1'b0};
        tb_reg   <= 65'(dt) * 65'(tau);
        num1_reg <= adt * adt;
    end

    logic signed [65:0]   msum;
    logic signed [MW-1:0] mask_reg;
    logic        [63:0]   num2_reg;

    assign msum = $signed({3'b000, sq_reg}) + 66'(tb_reg);

    always_ff @(posedge clk)
    begin
        mask_reg <= msum[65:FRAC_BITS];
        num2_reg <= num1_reg;
    end

    logic [63:0]   rem_reg [0:QB];
    logic [DW-1:0] den_reg [0:QB];
    logic [QB-1:0] q_reg   [0:QB];
    logic          zero_reg [0:QB];
    logic          zero_next;

    assign zero_next = (mask_reg <= 0)
        || (CW'(num2_reg) >= {mask_reg[DW-1:0], {QB{1'b0}}});

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= num2_reg;
        den_reg[0]  <= mask_reg[DW-1:0];
        q_reg[0]    <= '0;
        zero_reg[0] <= zero_next;
    end

    for (genvar j = 0; j < QB; j++)
    begin : g_div
        localparam int SH = QB - 1 - j;
        logic [CW-1:0] trial;
        logic          ge;
        logic [QB-1:0] q_next;

        assign trial = CW'(den_reg[j]) << SH;
        assign ge    = CW'(rem_reg[j]) >= trial;

        always_comb
        begin
            q_next     = q_reg[j];
            q_next[SH] = ge;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j+1]  <= ge ? 64'(CW'(rem_reg[j]) - trial) : rem_reg[j];
            den_reg[j+1]  <= den_reg[j];
            q_reg[j+1]    <= q_next;
            zero_reg[j+1] <= zero_reg[j];
        end
    end

    logic [YW-1:0] y_reg;
    logic          zy_reg;

    always_ff @(posedge clk)
    begin
        y_reg  <= YW'(q_reg[QB]) * YW'(degh_pkg::LOG2E_Q30);
        zy_reg <= zero_reg[QB];
    end

    logic [29:0] uf;
    logic [59:0] up;
    carry_t      c_reg [0:TERMS];
    logic [30:0] p_reg [1:TERMS];

    assign uf = y_reg[FRAC_BITS+29:FRAC_BITS];
    assign up = uf * degh_pkg::LN2_Q30;

    always_ff @(posedge clk)
    begin
        c_reg[0].u    <= up[59:30];
        c_reg[0].n    <= 6'(y_reg >> (FRAC_BITS + 30));
        c_reg[0].zero <= zy_reg;
    end

    for (genvar g = 0; g < TERMS; g++)
    begin : g_exp
        localparam int K = TERMS - g;
        logic [30:0] pin;
        logic [60:0] wp;
        logic [62:0] qm;
        logic [34:0] qk;
        logic [34:0] rm;
        logic [30:0] qf;
        logic [30:0] w_reg;
        logic [30:0] wb_reg;
        logic [30:0] q0_reg;
        carry_t      ca_reg;
        carry_t      cb_reg;

        if (g == 0)
        begin : g_first
            assign pin = degh_pkg::ONE_Q30;
        end
        else
        begin : g_rest
            assign pin = p_reg[g];
        end

        assign wp = c_reg[g].u * pin;
        assign qm = w_reg * degh_pkg::RECIP_Q31[K];
        assign qk = q0_reg * 4'(K);
        assign rm = 35'(wb_reg) - qk;
        assign qf = (rm >= 35'(K)) ? q0_reg + 31'd1 : q0_reg;

        always_ff @(posedge clk)
        begin
            w_reg      <= wp[60:30];
            ca_reg     <= c_reg[g];
            q0_reg     <= qm[61:31];
            wb_reg     <= w_reg;
            cb_reg     <= ca_reg;
            p_reg[g+1] <= degh_pkg::ONE_Q30 - qf;
            c_reg[g+1] <= cb_reg;
        end
    end

    logic [30:0] e_reg;
    logic [31:0] mag;
    logic [62:0] prod_reg;
    logic        neg_reg;
    logic [62:0] rsum;
    logic signed [33:0] rs;
    logic signed [33:0] peak_reg;

    assign mag  = amp[31] ? 32'(-amp) : 32'(amp);
    assign rsum = prod_reg + 63'(1 << 29);
    assign rs   = $signed({1'b0, rsum[62:30]});

    always_ff @(posedge clk)
    begin
        e_reg    <= c_reg[TERMS].zero ? '0 : 31'(p_reg[TERMS] >> c_reg[TERMS].n);
        prod_reg <= mag * e_reg;
        neg_reg  <= amp[31];
        peak_reg <= neg_reg ? -rs : rs;
    end

    assign peak = peak_reg;

endmodule

`default_nettype wire

/* hdl/dual_egh_pulse_evaluator_top.sv */
// Top level of the dual EGH pulse evaluator.
//
// Usage: raise start with sample_time and last_sample; the sample is taken on
// any clock edge with start high, since busy stays low and a new sample may
// follow in every cycle. Each sample gives one result: done is high for one
// cycle with pulse_value and last_result, and the result must be taken then.
// Throughput is one sample per clock. The depth is set by the bit-per-stage
// divider for the exponent argument (FRAC_BITS + 5 stages) and the
// twelve-term exp series at three stages per term; both peaks run side by
// side. Registers are written through wr_en, wr_index and wr_data; the user
// must write them only while no sample is in flight, which the block itself
// does not enforce; unknown indexes are dropped.
// Reset clears the flight line so no done comes out, zeroes amplitudes,
// tails and centre, and sets both widths to 1.0.
`default_nettype none

module dual_egh_pulse_evaluator_top #(
    parameter int FRAC_BITS = degh_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [31:0]             sample_time,
    input  logic                           last_sample,
    output logic                           done,
    output logic signed [31:0]             pulse_value,
    output logic                           last_result,
    input  logic                           wr_en,
    input  logic [degh_pkg::REG_IDX_W-1:0] wr_index,
    input  logic [31:0]                    wr_data
);

    localparam int LAT = degh_pkg::pipe_latency(FRAC_BITS);

    logic signed [31:0] amp_first_reg;
    logic signed [31:0] amp_second_reg;
    logic signed [31:0] tail_first_reg;
    logic signed [31:0] tail_second_reg;
    logic signed [31:0] centre_time_reg;
    logic        [30:0] width_first_reg;
    logic        [30:0] width_second_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_first_reg    <= '0;
            amp_second_reg   <= '0;
            tail_first_reg   <= '0;
            tail_second_reg  <= '0;
            centre_time_reg  <= '0;
            width_first_reg  <= 31'(1) << FRAC_BITS;
            width_second_reg <= 31'(1) << FRAC_BITS;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                degh_pkg::REG_AMP_FIRST:    amp_first_reg    <= wr_data;
                degh_pkg::REG_AMP_SECOND:   amp_second_reg   <= wr_data;
                degh_pkg::REG_TAIL_FIRST:   tail_first_reg   <= wr_data;
                degh_pkg::REG_TAIL_SECOND:  tail_second_reg  <= wr_data;
                degh_pkg::REG_CENTRE_TIME:  centre_time_reg  <= wr_data;
                degh_pkg::REG_WIDTH_FIRST:  width_first_reg  <= wr_data[30:0];
                degh_pkg::REG_WIDTH_SECOND: width_second_reg <= wr_data[30:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], start & ~busy};
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= {last_reg[LAT-2:0], last_sample};
    end

    logic signed [32:0] dt_next;
    logic signed [32:0] dt_reg;
    logic        [31:0] adt_reg;

    assign dt_next = 33'(sample_time) - 33'(centre_time_reg);

    always_ff @(posedge clk)
    begin
        dt_reg  <= dt_next;
        adt_reg <= dt_next[32] ? 32'(-dt_next) : dt_next[31:0];
    end

    logic signed [33:0] peak_first;
    logic signed [33:0] peak_second;

    degh_peak #(.FRAC_BITS(FRAC_BITS)) u_peak_first (
        .clk   (clk),
        .dt    (dt_reg),
        .adt   (adt_reg),
        .amp   (amp_first_reg),
        .tau   (tail_first_reg),
        .sigma (width_first_reg),
        .peak  (peak_first)
    );

    degh_peak #(.FRAC_BITS(FRAC_BITS)) u_peak_second (
        .clk   (clk),
        .dt    (dt_reg),
        .adt   (adt_reg),
        .amp   (amp_second_reg),
        .tau   (tail_second_reg),
        .sigma (width_second_reg),
        .peak  (peak_second)
    );

    logic signed [34:0] psum;
    logic signed [31:0] pulse_reg;

    assign psum = 35'(peak_first) + 35'(peak_second);

    always_ff @(posedge clk)
    begin
        if (psum > 35'sd2147483647)
        begin
            pulse_reg <= 32'sh7FFFFFFF;
        end
        else if (psum < -35'sd2147483648)
        begin
            pulse_reg <= 32'sh80000000;
        end
        else
        begin
            pulse_reg <= psum[31:0];
        end
    end

    assign done        = vld_reg[LAT-1];
    assign last_result = last_reg[LAT-1];
    assign pulse_value = pulse_reg;

endmodule

`default_nettype wire

/* hdl/degh_checker.sv */
// Port-level checks for the dual EGH pulse evaluator, bound to the top level.
`default_nettype none

module degh_checker #(
    parameter int FRAC_BITS = degh_pkg::FRAC_BITS_DEF
) (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic last_sample,
    input logic done,
    input logic last_result
);

    localparam int LAT = degh_pkg::pipe_latency(FRAC_BITS);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("transfer gave no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without transfer");

    a_last_kept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (last_result == $past(last_sample, LAT)))
        else $error("last flag mismatch");

endmodule

bind dual_egh_pulse_evaluator_top degh_checker #(.FRAC_BITS(FRAC_BITS)) u_degh_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .last_sample (last_sample),
    .done        (done),
    .last_result (last_result)
);

`default_nettype wire

/* verif/dual_egh_pulse_evaluator_top_tb.sv */
// Self-checking testbench for the dual EGH pulse evaluator: predictor and stream check.
`default_nettype none

module dual_egh_pulse_evaluator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = degh_pkg::FRAC_BITS_DEF;
    localparam int LAT = degh_pkg::pipe_latency(FB);
    localparam longint LIMIT = 400000;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } pulse_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [31:0] sample_time = '0;
    logic last_sample = 1'b0;
    logic done;
    logic signed [31:0] pulse_value;
    logic last_result;
    logic wr_en = 1'b0;
    logic [degh_pkg::REG_IDX_W-1:0] wr_index = '0;
    logic [31:0] wr_data = '0;

    longint amp1, amp2, tail1, tail2, centre;
    longint unsigned sig1, sig2;
    pulse_t pulse_q[$];
    int errors = 0;
    int sent = 0;
    int checked = 0;
    int configs = 0;
    longint cycles = 0;

    dual_egh_pulse_evaluator_top dut (.*);

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout at %0t", $time);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic longint unsigned neg_exp(longint unsigned x);
        longint unsigned y, n, u, p;
        if (x >= (64'd32 << FB))
            return 0;
        y = x * 64'd1549082005;
        n = y >> (FB + 30);
        u = (((y & ((64'd1 << (FB + 30)) - 1)) >> FB) * 64'd744261118) >> 30;
        p = 64'd1 << 30;
        for (int k = degh_pkg::EXP_TERMS; k >= 1; k--)
            p = (64'd1 << 30) - ((u * p) >> 30) / k;
        if (n >= 63)
            return 0;
        return p >> n;
    endfunction

    function automatic longint peak(longint dt, longint amp, longint tau, longint unsigned sg);
        longint unsigned a, ub, adt, x, mag, r, lowm;
        longint b, bhi, msk;
        lowm = (64'd1 << FB) - 1;
        a = (sg * sg) << 1;
        b = dt * tau;
        ub = b;
        bhi = b >>> FB;
        msk = longint'(a >> FB) + bhi + longint'(((a & lowm) + (ub & lowm)) >> FB);
        if (msk <= 0)
            return 0;
        adt = (dt < 0) ? -dt : dt;
        x = (adt * adt) / longint'(msk);
        mag = (amp < 0) ? -amp : amp;
        r = (mag * neg_exp(x) + (64'd1 << 29)) >> 30;
        return (amp < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic pulse_t predict_pulse(logic signed [31:0] t, logic lst);
        pulse_t res;
        longint dt, s;
        dt = longint'(t) - centre;
        s = peak(dt, amp1, tail1, sig1) + peak(dt, amp2, tail2, sig2);
        if (s > 64'sd2147483647)
            s = 64'sd2147483647;
        if (s < -64'sd2147483648)
            s = -64'sd2147483648;
        res.value = s[31:0];
        res.last = lst;
        return res;
    endfunction

    always @(posedge clk)
    begin
        pulse_t exp_p;
        if (done)
        begin
            if (pulse_q.size() == 0)
            begin
                $display("%0t unexpected result %0d", $time, pulse_value);
                errors++;
            end
            else
            begin
                exp_p = pulse_q.pop_front();
                checked++;
                if (pulse_value !== exp_p.value)
                begin
                    $display("%0t pulse_value exp %0d got %0d",
                             $time, exp_p.value, pulse_value);
                    errors++;
                end
                if (last_result !== exp_p.last)
                begin
                    $display("%0t last_result exp %0b got %0b",
                             $time, exp_p.last, last_result);
                    errors++;
                end
            end
        end
    end

    task automatic idle_gap();
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            g = 0;
        repeat (g) @(posedge clk);
    endtask

    task automatic send_sample(logic signed [31:0] t, logic lst, bit gaps);
        start <= 1'b1;
        sample_time <= t;
        last_sample <= lst;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pulse_q.push_back(predict_pulse(t, lst));
        sent++;
        if (gaps && $urandom_range(0, 2) == 0)
        begin
            start <= 1'b0;
            @(posedge clk);
            idle_gap();
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pulse_q.size() != 0)
            @(posedge clk);
        repeat (LAT + 4) @(posedge clk);
    endtask

    task automatic write_reg(logic [degh_pkg::REG_IDX_W-1:0] idx, logic [31:0] val);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        configs++;
        case (idx)
            degh_pkg::REG_AMP_FIRST:    amp1 = longint'(signed'(val));
            degh_pkg::REG_AMP_SECOND:   amp2 = longint'(signed'(val));
            degh_pkg::REG_TAIL_FIRST:   tail1 = longint'(signed'(val));
            degh_pkg::REG_TAIL_SECOND:  tail2 = longint'(signed'(val));
            degh_pkg::REG_CENTRE_TIME:  centre = longint'(signed'(val));
            degh_pkg::REG_WIDTH_FIRST:  sig1 = val[30:0];
            degh_pkg::REG_WIDTH_SECOND: sig2 = val[30:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic load_set(logic [31:0] a1, logic [31:0] a2, logic [31:0] t1,
                            logic [31:0] t2, logic [31:0] c, logic [31:0] s1,
                            logic [31:0] s2);
        write_reg(degh_pkg::REG_AMP_FIRST, a1);
        write_reg(degh_pkg::REG_AMP_SECOND, a2);
        write_reg(degh_pkg::REG_TAIL_FIRST, t1);
        write_reg(degh_pkg::REG_TAIL_SECOND, t2);
        write_reg(degh_pkg::REG_CENTRE_TIME, c);
        write_reg(degh_pkg::REG_WIDTH_FIRST, s1);
        write_reg(degh_pkg::REG_WIDTH_SECOND, s2);
        @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        send_sample(32'sh0000_0000, 1'b0, 1'b0);
        send_sample(32'sh0001_0000, 1'b1, 1'b0);
        drain();
    endtask

    task automatic test_directed();
        load_set(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'hFFFF_C000,
                 32'h0000_0000, 32'h0001_0000, 32'h0002_0000);
        send_sample(32'sh7FFF_FFFF, 1'b1, 1'b0);
        send_sample(-32'sh8000_0000, 1'b0, 1'b0);
        send_sample(32'sh0000_0000, 1'b1, 1'b0);
        send_sample(32'sh0000_0001, 1'b0, 1'b0);
        send_sample(-32'sh0000_0001, 1'b0, 1'b0);
        send_sample(32'sh0008_0000, 1'b0, 1'b0);
        send_sample(-32'sh0008_0000, 1'b1, 1'b0);
        drain();
        // sum overflow high, tiny mask, unknown index, upper width bits
        load_set(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0,
                 32'hFFFF_FFFF, 32'h8000_0000);
        write_reg({degh_pkg::REG_IDX_W{1'b1}}, 32'hDEAD_BEEF);
        send_sample(32'sh0, 1'b0, 1'b0);
        send_sample(32'sh0000_0100, 1'b1, 1'b0);
        drain();
        load_set(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
        send_sample(-32'sh8000_0000, 1'b1, 1'b0);
        send_sample(32'sh7FFF_FFFF, 1'b0, 1'b0);
        send_sample(32'sh0, 1'b0, 1'b0);
        drain();
        load_set(32'hFFFF_0000, 32'h0003_0000, 32'h0001_0000, 32'hFFFF_0000,
                 32'h0010_0000, 32'h0000_0001, 32'h0000_0100);
        send_sample(32'sh0010_0000, 1'b0, 1'b0);
        send_sample(32'sh0010_0001, 1'b0, 1'b0);
        send_sample(32'sh0011_0000, 1'b1, 1'b0);
        send_sample(32'sh0040_0000, 1'b0, 1'b0);
        drain();
    endtask

    function automatic logic [31:0] rand_q(int scale);
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $urandom_range(0, 32'h0004_0000) << $urandom_range(0, scale);
            2: v = -($urandom_range(0, 32'h0004_0000) << $urandom_range(0, scale));
            default: v = $urandom_range(0, 32'h0000_4000);
        endcase
        return v;
    endfunction

    task automatic test_random();
        for (int ph = 0; ph < 13; ph++)
        begin
            load_set(rand_q(14), rand_q(14), rand_q(4), rand_q(4), rand_q(8),
                     rand_q(6), rand_q(6));
            for (int i = 0; i < 50; i++)
            begin
                logic signed [31:0] t;
                t = ($urandom_range(0, 4) == 0) ? 32'($urandom)
                    : 32'(centre + longint'($urandom_range(0, 32'h000C_0000))
                          - 64'sh0006_0000);
                send_sample(t, 1'($urandom_range(0, 1)), 1'b1);
            end
            drain();
        end
    endtask

    initial
    begin
        amp1 = 0; amp2 = 0; tail1 = 0; tail2 = 0; centre = 0;
        sig1 = 64'd1 << FB; sig2 = 64'd1 << FB;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_reset_defaults();
        test_directed();
        test_random();
        drain();
        $display("covered %0d samples over %0d register writes, %0d results checked",
                 sent, configs, checked);
        $display("register sets included extreme amplitudes, tails, centres and widths");
        if (errors == 0 && pulse_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
hdl/degh_pkg.sv
hdl/degh_peak.sv
hdl/dual_egh_pulse_evaluator_top.sv
hdl/degh_checker.sv
verif/dual_egh_pulse_evaluator_top_tb.sv
